// ----- rtl/lcdw_pkg.sv -----
// Shared types, the glyph table and the cell position map of the LCD segment writer.
package lcdw_pkg;

	localparam int unsigned NumCells  = 6;
	localparam int unsigned NumPlanes = 4;
	localparam logic [7:0]  TableSize = 8'h60;

	// One classified item as it travels from the front part to the back part.
	typedef struct packed {
		logic        applied;
		logic        clear_first;
		logic [2:0]  digit;
		logic [15:0] glyph;
	} cmd_t;

	// Bit positions p1..p4 of one character cell inside a 32-bit plane word.
	typedef struct packed {
		logic [4:0] p1;
		logic [4:0] p2;
		logic [4:0] p3;
		logic [4:0] p4;
	} cell_pos_t;

	typedef logic [31:0] plane_word_t;

	// Bits 0..13 are segments A..N, bit 14 the decimal point, bit 15 the colon.
	localparam logic [15:0] GLYPH_TABLE [0:95] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h3FC0, 16'h1540, 16'h0000, 16'h0440, 16'h4000, 16'h2200,
		16'h003F, 16'h0006, 16'h045B, 16'h044F, 16'h0466, 16'h046D, 16'h047D, 16'h2201,
		16'h047F, 16'h046F, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0477, 16'h047C, 16'h0039, 16'h045E, 16'h0479, 16'h0471, 16'h043D,
		16'h0476, 16'h1109, 16'h001E, 16'h1B00, 16'h0038, 16'h02B6, 16'h08B6, 16'h003F,
		16'h0473, 16'h0467, 16'h0C73, 16'h046D, 16'h1101, 16'h003E, 16'h0886, 16'h2836,
		16'h2A80, 16'h1280, 16'h2209, 16'h0000, 16'h0880, 16'h0000, 16'h0000, 16'h0008
	};

	function automatic logic [15:0] glyph_lookup(input logic [7:0] code);
		logic [15:0] mask;
		mask = 16'h0000;
		if (code < TableSize) begin
			mask = GLYPH_TABLE[code[6:0]];
		end
		return mask;
	endfunction

	function automatic cell_pos_t cell_positions(input logic [2:0] digit);
		cell_pos_t pos;
		case (digit)
			3'd0: pos = '{p1: 5'd0,  p2: 5'd1,  p3: 5'd29, p4: 5'd28};
			3'd1: pos = '{p1: 5'd2,  p2: 5'd7,  p3: 5'd27, p4: 5'd26};
			3'd2: pos = '{p1: 5'd8,  p2: 5'd9,  p3: 5'd25, p4: 5'd24};
			3'd3: pos = '{p1: 5'd10, p2: 5'd11, p3: 5'd21, p4: 5'd20};
			3'd4: pos = '{p1: 5'd12, p2: 5'd13, p3: 5'd19, p4: 5'd18};
			3'd5: pos = '{p1: 5'd14, p2: 5'd15, p3: 5'd16, p4: 5'd17};
			default: pos = '{p1: 5'd0, p2: 5'd0, p3: 5'd0, p4: 5'd0};
		endcase
		return pos;
	endfunction

	// Places one mask bit at a position of a plane word.
	function automatic plane_word_t place_bit(input logic bit_val, input logic [4:0] pos);
		return plane_word_t'({31'd0, bit_val}) << pos;
	endfunction

endpackage

// ----- rtl/lcdw_front.sv -----
// Front part: range check of the incoming item and glyph table lookup.
module lcdw_front (
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [2:0]         digit_position,
	input  logic [7:0]         char_code,
	input  logic               clear_first,
	output logic               cmd_valid,
	input  logic               cmd_full,
	output lcdw_pkg::cmd_t     cmd
);

	logic in_range;

	assign in_range = (digit_position < 3'(lcdw_pkg::NumCells)) &&
	                  (char_code < lcdw_pkg::TableSize);

	// The queue behind is the register of this part; it stalls us when full.
	assign item_stall = cmd_full;
	assign cmd_valid  = item_valid;

	always_comb begin
		cmd.applied     = in_range;
		cmd.clear_first = clear_first;
		cmd.digit       = digit_position;
		cmd.glyph       = lcdw_pkg::glyph_lookup(char_code);
	end

endmodule

// ----- rtl/lcdw_queue.sv -----
// Two-entry command queue between the front and back parts.
module lcdw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lcdw_pkg::cmd_t     push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output lcdw_pkg::cmd_t     head_cmd
);

	lcdw_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/lcdw_back.sv -----
// Back part: read-modify-write of the four common-plane words and the result register.
module lcdw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  lcdw_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        plane0_word,
	output logic [31:0]        plane1_word,
	output logic [31:0]        plane2_word,
	output logic [31:0]        plane3_word,
	output logic               applied
);

	lcdw_pkg::plane_word_t planes_q [lcdw_pkg::NumPlanes];
	lcdw_pkg::plane_word_t planes_next [lcdw_pkg::NumPlanes];
	lcdw_pkg::plane_word_t set_bits [lcdw_pkg::NumPlanes];
	lcdw_pkg::plane_word_t clear_mask;
	lcdw_pkg::cell_pos_t   pos;
	logic                  result_valid_q;
	lcdw_pkg::plane_word_t out_word_q [lcdw_pkg::NumPlanes];
	logic                  applied_q;

	// A new command moves in whenever the result register is empty or being taken.
	assign cmd_pop = cmd_valid && (!result_valid_q || !result_stall);

	always_comb begin
		pos = lcdw_pkg::cell_positions(cmd.digit);
		clear_mask = lcdw_pkg::place_bit(1'b1, pos.p1) | lcdw_pkg::place_bit(1'b1, pos.p2) |
		             lcdw_pkg::place_bit(1'b1, pos.p3) | lcdw_pkg::place_bit(1'b1, pos.p4);
		set_bits[0] = lcdw_pkg::place_bit(cmd.glyph[1], pos.p4) |
		              lcdw_pkg::place_bit(cmd.glyph[4], pos.p1) |
		              lcdw_pkg::place_bit(cmd.glyph[6], pos.p3) |
		              lcdw_pkg::place_bit(cmd.glyph[10], pos.p2);
		set_bits[1] = lcdw_pkg::place_bit(cmd.glyph[0], pos.p4) |
		              lcdw_pkg::place_bit(cmd.glyph[2], pos.p2) |
		              lcdw_pkg::place_bit(cmd.glyph[3], pos.p1) |
		              lcdw_pkg::place_bit(cmd.glyph[5], pos.p3);
		set_bits[2] = lcdw_pkg::place_bit(cmd.glyph[9], pos.p4) |
		              lcdw_pkg::place_bit(cmd.glyph[12], pos.p1) |
		              lcdw_pkg::place_bit(cmd.glyph[13], pos.p3) |
		              lcdw_pkg::place_bit(cmd.glyph[15], pos.p2);
		set_bits[3] = lcdw_pkg::place_bit(cmd.glyph[7], pos.p3) |
		              lcdw_pkg::place_bit(cmd.glyph[8], pos.p4) |
		              lcdw_pkg::place_bit(cmd.glyph[11], pos.p1) |
		              lcdw_pkg::place_bit(cmd.glyph[14], pos.p2);
		for (int i = 0; i < lcdw_pkg::NumPlanes; i++) begin
			planes_next[i] = planes_q[i];
			if (cmd.applied) begin
				if (cmd.clear_first) begin
					planes_next[i] = planes_next[i] & ~clear_mask;
				end
				planes_next[i] = planes_next[i] | set_bits[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lcdw_pkg::NumPlanes; i++) begin
				planes_q[i] <= '0;
			end
			result_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				for (int i = 0; i < lcdw_pkg::NumPlanes; i++) begin
					planes_q[i] <= planes_next[i];
				end
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			for (int i = 0; i < lcdw_pkg::NumPlanes; i++) begin
				out_word_q[i] <= planes_next[i];
			end
			applied_q <= cmd.applied;
		end
	end

	assign result_valid = result_valid_q;
	assign plane0_word  = out_word_q[0];
	assign plane1_word  = out_word_q[1];
	assign plane2_word  = out_word_q[2];
	assign plane3_word  = out_word_q[3];
	assign applied      = applied_q;

endmodule

// ----- rtl/ascii_to_lcd_segment_ram_writer.sv -----
// Top level of the fourteen-segment LCD character writer for a six-cell display.
// Usage: the host offers an item (digit_position, char_code, clear_first) with
// item_valid; it is taken at a rising edge where item_valid is high and item_stall
// is low. For every item one result comes back on the result channel: the four
// common-plane words after the update and the applied flag, taken at an edge where
// result_valid is high and result_stall is low.
// An accepted item is written into the queue and then moves into the result
// register, where result_valid rises. One item per cycle is sustained while
// result_stall is low; the rate is set by the read-modify-write of the four
// plane registers in the back part, done as each item enters the result register.
// The front part range-checks the item and looks up its 16-bit segment mask; a
// two-entry queue then hands it to the back part, which clears (on clear_first)
// and sets the four bit positions of that cell in every plane word. Items with
// a code of 0x60 or above, or a cell of 6 or 7, leave the planes alone and report
// applied low. Reset clears the plane words to zero and empties the queue and
// result register. When the receiver stalls, the result register holds its item,
// up to two more items wait in the queue, and only then is item_stall raised.
module ascii_to_lcd_segment_ram_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  digit_position,
	input  logic [7:0]  char_code,
	input  logic        clear_first,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] plane0_word,
	output logic [31:0] plane1_word,
	output logic [31:0] plane2_word,
	output logic [31:0] plane3_word,
	output logic        applied
);

	// Classified item from the front part and the queue head it becomes.
	logic           front_valid;
	lcdw_pkg::cmd_t front_cmd;
	logic           queue_full;
	logic           queue_pop;
	logic           head_valid;
	lcdw_pkg::cmd_t head_cmd;

	// The front part never holds an item of its own; the queue is its register.
	lcdw_front u_front (
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.digit_position (digit_position),
		.char_code      (char_code),
		.clear_first    (clear_first),
		.cmd_valid      (front_valid),
		.cmd_full       (queue_full),
		.cmd            (front_cmd)
	);

	// The queue lets the front keep accepting while a result waits to be taken.
	lcdw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_cmd   (front_cmd),
		.full       (queue_full),
		.pop        (queue_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back part owns the plane words and the result register.
	lcdw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (head_valid),
		.cmd          (head_cmd),
		.cmd_pop      (queue_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.plane0_word  (plane0_word),
		.plane1_word  (plane1_word),
		.plane2_word  (plane2_word),
		.plane3_word  (plane3_word),
		.applied      (applied)
	);

endmodule

// ----- rtl/lcdw_checker.sv -----
// Port-level checker of the LCD segment writer and its bind to the top level.
module lcdw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_stall,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [31:0] plane0_word,
	input  logic [31:0] plane1_word,
	input  logic [31:0] plane2_word,
	input  logic [31:0] plane3_word,
	input  logic        applied
);

	logic [31:0] last_word_q [4];
	logic        result_take;

	assign result_take = result_valid && !result_stall;

	// Plane words of the last delivered result; zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				last_word_q[i] <= '0;
			end
		end else if (result_take) begin
			last_word_q[0] <= plane0_word;
			last_word_q[1] <= plane1_word;
			last_word_q[2] <= plane2_word;
			last_word_q[3] <= plane3_word;
		end
	end

	// A stalled result keeps its item.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(plane0_word) &&
		$stable(plane1_word) && $stable(plane2_word) && $stable(plane3_word) &&
		$stable(applied))
		else $error("stalled result changed");

	// An ignored item reports the planes exactly as the previous result left them.
	a_ignored_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		result_take && !applied |-> plane0_word == last_word_q[0] &&
		plane1_word == last_word_q[1] && plane2_word == last_word_q[2] &&
		plane3_word == last_word_q[3])
		else $error("ignored item changed the plane words");

	// The input side only backs up behind a result that is waiting.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with no result pending");

endmodule

bind ascii_to_lcd_segment_ram_writer lcdw_checker u_lcdw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.plane0_word  (plane0_word),
	.plane1_word  (plane1_word),
	.plane2_word  (plane2_word),
	.plane3_word  (plane3_word),
	.applied      (applied)
);
